// ----- src/nsr_pkg.sv -----
// ---------------------------------------------------------------------------
// nsr_pkg
// Shared types and constants for the Newton square root unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

  // Field widths fixed by the interface
  localparam int ROOT_W    = 32;
  localparam int ITER_W    = 6;
  localparam int TOL_W     = 32;
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;
  localparam int OUT_DAT_W = 40;

  // Default fraction bit count
  localparam int FRAC_BITS_DEF = 16;

  // Divider geometry: 65-bit numerator, 33-bit divisor (2r)
  localparam int DIV_NUM_W = SQ_W + 1;
  localparam int DIV_DEN_W = ROOT_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'b1;

  // Register reset values
  localparam logic [TOL_W-1:0]  TOL_RESET      = 32'd65536;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 6'd40;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIFF,
    ST_TEST,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic square;
    logic diff;
    logic div_start;
    logic update;
    logic set_conv;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pass;
    logic stop;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/nsr_div.sv -----
// ---------------------------------------------------------------------------
// nsr_div
// Restoring divider, one quotient bit per cycle, quotient saturated to
// 32 bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsr_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [nsr_pkg::DIV_NUM_W-1:0]   dividend_i,
  input  wire logic [nsr_pkg::DIV_DEN_W-1:0]   divisor_i,
  output logic                                 done_o,
  output logic [nsr_pkg::ROOT_W-1:0]           quotient_o
);

  localparam int NumW = nsr_pkg::DIV_NUM_W;
  localparam int DenW = nsr_pkg::DIV_DEN_W;
  localparam int CntW = nsr_pkg::DIV_CNT_W;
  localparam int RootW = nsr_pkg::ROOT_W;
  localparam logic [CntW-1:0] LastStep = CntW'(NumW - 1);

  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] quo_q;
  logic             ovf_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  logic [DenW:0]    rem_shift, rem_sub;
  logic             ge;

  // Shift in the next numerator bit and try the subtraction
  always_comb begin
    rem_shift = {rem_q, num_q[NumW-1]};
    rem_sub   = rem_shift - {1'b0, den_q};
    ge        = rem_shift >= {1'b0, den_q};
    rem_d     = ge ? rem_sub[DenW-1:0] : rem_shift[DenW-1:0];
  end

  // Control: step counter, busy and done flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, quotient and sticky overflow
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[RootW-2:0], ge};
      ovf_q <= ovf_q | quo_q[RootW-1];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = ovf_q ? {RootW{1'b1}} : quo_q;

endmodule

`default_nettype wire

// ----- src/nsr_datapath.sv -----
// ---------------------------------------------------------------------------
// nsr_datapath
// Guess, square, error and result registers, configuration registers and
// the serial divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsr_datapath #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [nsr_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  wire logic [nsr_pkg::ROOT_W-1:0]       value_i,
  input  wire nsr_pkg::cmd_t                    cmd_i,
  output nsr_pkg::sts_t                         sts_o,
  output logic [nsr_pkg::ROOT_W-1:0]            root_o,
  output logic                                  conv_o,
  output logic [nsr_pkg::ITER_W-1:0]            used_o
);

  localparam int RootW = nsr_pkg::ROOT_W;
  localparam int SqW   = nsr_pkg::SQ_W;
  localparam int IterW = nsr_pkg::ITER_W;
  localparam int TolW  = nsr_pkg::TOL_W;
  localparam int WideW = RootW + FRAC_BITS;
  localparam logic [RootW-1:0] One = RootW'(1) << FRAC_BITS;

  logic [TolW-1:0]  tol_q;
  logic [IterW-1:0] max_iter_q;
  logic [WideW-1:0] w_q;
  logic [RootW-1:0] r_q;
  logic [IterW-1:0] used_q;
  logic [SqW-1:0]   sq_q;
  logic [SqW-1:0]   err_q;
  logic             conv_q;
  logic [RootW-1:0] out_root_q;
  logic             out_conv_q;
  logic [IterW-1:0] out_used_q;

  logic [SqW-1:0]                  w_ext;
  logic [nsr_pkg::DIV_NUM_W-1:0]   sum;
  logic                            div_done;
  logic [RootW-1:0]                quotient;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= nsr_pkg::TOL_RESET;
      max_iter_q <= nsr_pkg::MAX_ITER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nsr_pkg::REG_TOLERANCE: tol_q      <= cfg_data_i[TolW-1:0];
        nsr_pkg::REG_MAX_ITER:  max_iter_q <= cfg_data_i[IterW-1:0];
        default: ;
      endcase
    end
  end

  assign w_ext = SqW'(w_q);
  assign sum   = {1'b0, sq_q} + nsr_pkg::DIV_NUM_W'(w_q);

  // Iteration registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q    <= {value_i, {FRAC_BITS{1'b0}}};
      r_q    <= One;
      used_q <= '0;
      conv_q <= 1'b0;
    end
    if (cmd_i.square) begin
      sq_q <= r_q * r_q;
    end
    if (cmd_i.diff) begin
      err_q <= (sq_q >= w_ext) ? (sq_q - w_ext) : (w_ext - sq_q);
    end
    if (cmd_i.update) begin
      r_q    <= quotient;
      used_q <= used_q + 1'b1;
    end
    if (cmd_i.set_conv) begin
      conv_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_root_q <= r_q;
      out_conv_q <= conv_q;
      out_used_q <= used_q;
    end
  end

  // Shared serial divider for (r*r + w) / 2r
  nsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum),
    .divisor_i  ({r_q, 1'b0}),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Status towards the controller
  always_comb begin
    sts_o.pass     = (err_q[SqW-1:TolW] == '0) && (err_q[TolW-1:0] <= tol_q);
    sts_o.stop     = (used_q >= max_iter_q) || (r_q == '0);
    sts_o.div_done = div_done;
  end

  assign root_o = out_root_q;
  assign conv_o = out_conv_q;
  assign used_o = out_used_q;

endmodule

`default_nettype wire

// ----- src/nsr_ctrl.sv -----
// ---------------------------------------------------------------------------
// nsr_ctrl
// Sequencer for the Newton iteration and the input and output handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nsr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire nsr_pkg::sts_t sts_i,
  output nsr_pkg::cmd_t      cmd_o
);

  nsr_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // State and output flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nsr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      nsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = nsr_pkg::ST_SQUARE;
        end
      end
      nsr_pkg::ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = nsr_pkg::ST_DIFF;
      end
      nsr_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = nsr_pkg::ST_TEST;
      end
      nsr_pkg::ST_TEST: begin
        priority if (sts_i.pass) begin
          cmd_o.set_conv = 1'b1;
          state_d        = nsr_pkg::ST_FINISH;
        end else if (sts_i.stop) begin
          state_d = nsr_pkg::ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = nsr_pkg::ST_DIVIDE;
        end
      end
      nsr_pkg::ST_DIVIDE: begin
        if (sts_i.div_done) begin
          cmd_o.update = 1'b1;
          state_d      = nsr_pkg::ST_SQUARE;
        end
      end
      nsr_pkg::ST_FINISH: begin
        // Hand over once the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = nsr_pkg::ST_IDLE;
        end
      end
      default: state_d = nsr_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- src/newton_square_root_unit.sv -----
// ---------------------------------------------------------------------------
// newton_square_root_unit
// Unsigned fixed-point square root by Newton iteration with tolerance and
// iteration limit registers.
// ---------------------------------------------------------------------------
//  Channel   Direction  Transfer when             Content
//  s_axis    in         tvalid & tready           radicand
//  m_axis    out        tvalid & tready           root, iteration count, flag
//  cfg       in         cfg_we_i                  tolerance / iteration limit
//
//  Each Newton update is dominated by the 65-step restoring divider, plus
//  square and error steps. One item is in flight at a time; the next is
//  taken once the result sits in the output register, which holds it until
//  the downstream transfer. No clearing pass after reset; the control,
//  divider control and configuration registers return to their reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module newton_square_root_unit #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // value_in[31:0]
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [nsr_pkg::ROOT_W-1:0]       s_axis_tdata,
  // root_out[31:0], iterations_used[37:32], zero pad[39:38]
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [nsr_pkg::OUT_DAT_W-1:0]         m_axis_tdata,
  // converged[0]
  output logic                                  m_axis_tuser,
  input  wire logic                             cfg_we_i,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [nsr_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  localparam int PadW = nsr_pkg::OUT_DAT_W - nsr_pkg::ROOT_W - nsr_pkg::ITER_W;

  nsr_pkg::cmd_t               cmd;
  nsr_pkg::sts_t               sts;
  logic [nsr_pkg::ROOT_W-1:0]  root;
  logic                        conv;
  logic [nsr_pkg::ITER_W-1:0]  used;

  nsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nsr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .root_o      (root),
    .conv_o      (conv),
    .used_o      (used)
  );

  // Pack the result fields
  assign m_axis_tdata = {{PadW{1'b0}}, used, root};
  assign m_axis_tuser = conv;

endmodule

`default_nettype wire
